[sv/ddarw_pkg.sv]
// ----------------------------------------------------------------------------
// ddarw_pkg
// Shared constants, result codes and controller/datapath bundles of the grid
// ray walker.
// ----------------------------------------------------------------------------
`default_nettype none

package ddarw_pkg;

   localparam int MAP_SIZE_DEF  = 64;
   localparam int MAX_STEPS_DEF = 128;

   localparam int PW = 6;   // map index field width
   localparam int QW = 32;  // Q16.16 distance width
   localparam int VW = 8;   // map byte width
   localparam int SW = 2;   // step code width

   localparam logic [VW-1:0] WALL_CHAR = 8'd49;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_WALL   = 2'd0,
      STATUS_NO_HIT = 2'd1,
      STATUS_WRITE  = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic       clear;       // write one map entry of the clearing pass
      logic       load;        // request accepted: latch it, write map on a write request to an in-grid cell
      logic       step;        // take one walk step and issue the map read
      logic       finish;      // load the response register
      status_type fin_status;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;     // clearing pass at its last entry
      logic req_cast;       // incoming request is a cast
      logic start_in_grid;  // incoming start cell lies in the grid
      logic next_in_grid;   // cell of the pending step lies in the grid
      logic wall;           // map read of the current cell says wall
      logic step_limit;     // step count reached its limit
      logic out_free;       // response register can take a new response
   } dp_status_type;

endpackage

`default_nettype wire

[sv/ddarw_if.sv]
// ----------------------------------------------------------------------------
// ddarw request / response channels
// Valid/ready channels carrying the walker's request and response payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddarw_req_if;
   logic                            valid;
   logic                            ready;
   logic                            cmd;
   logic [ddarw_pkg::PW-1:0]        pos_x;
   logic [ddarw_pkg::PW-1:0]        pos_y;
   logic [ddarw_pkg::VW-1:0]        cell_value;
   logic [ddarw_pkg::QW-1:0]        side_x;
   logic [ddarw_pkg::QW-1:0]        side_y;
   logic [ddarw_pkg::QW-1:0]        delta_x;
   logic [ddarw_pkg::QW-1:0]        delta_y;
   logic signed [ddarw_pkg::SW-1:0] step_x;
   logic signed [ddarw_pkg::SW-1:0] step_y;

   modport source (
      output valid, cmd, pos_x, pos_y, cell_value, side_x, side_y,
             delta_x, delta_y, step_x, step_y,
      input  ready
   );
   modport sink (
      input  valid, cmd, pos_x, pos_y, cell_value, side_x, side_y,
             delta_x, delta_y, step_x, step_y,
      output ready
   );
endinterface

interface ddarw_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic [ddarw_pkg::PW-1:0] hit_x;
   logic [ddarw_pkg::PW-1:0] hit_y;
   logic                     hit_side;
   logic [ddarw_pkg::QW-1:0] end_side_x;
   logic [ddarw_pkg::QW-1:0] end_side_y;

   modport source (
      output valid, status, hit_x, hit_y, hit_side, end_side_x, end_side_y,
      input  ready
   );
   modport sink (
      input  valid, status, hit_x, hit_y, hit_side, end_side_x, end_side_y,
      output ready
   );
endinterface

`default_nettype wire

[sv/ddarw_ram.sv]
// ----------------------------------------------------------------------------
// ddarw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ddarw_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/ddarw_ctrl.sv]
// ----------------------------------------------------------------------------
// ddarw_ctrl
// Walker sequencer: clearing pass, request accept, step/check loop, response.
// ----------------------------------------------------------------------------
`default_nettype none

module ddarw_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire ddarw_pkg::dp_status_type status,
   output      ddarw_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_CHECK,
      ST_DONE
   } state_type;

   state_type             state_ff;
   ddarw_pkg::status_type fin_status_ff;

   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      cmd.clear      = (state_ff == ST_CLEAR);
      cmd.load       = req_ready && req_valid;
      cmd.step       = (state_ff == ST_STEP);
      cmd.finish     = (state_ff == ST_DONE) && status.out_free;
      cmd.fin_status = fin_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         fin_status_ff <= ddarw_pkg::STATUS_NO_HIT;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  priority if (!status.req_cast) begin
                     fin_status_ff <= ddarw_pkg::STATUS_WRITE;
                     state_ff      <= ST_DONE;
                  end else if (!status.start_in_grid) begin
                     fin_status_ff <= ddarw_pkg::STATUS_NO_HIT;
                     state_ff      <= ST_DONE;
                  end else begin
                     state_ff <= ST_STEP;
                  end
               end
            end
            ST_STEP: begin
               if (!status.next_in_grid) begin
                  fin_status_ff <= ddarw_pkg::STATUS_NO_HIT;
                  state_ff      <= ST_DONE;
               end else begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               priority if (status.wall) begin
                  fin_status_ff <= ddarw_pkg::STATUS_WALL;
                  state_ff      <= ST_DONE;
               end else if (status.step_limit) begin
                  fin_status_ff <= ddarw_pkg::STATUS_NO_HIT;
                  state_ff      <= ST_DONE;
               end else begin
                  state_ff <= ST_STEP;
               end
            end
            ST_DONE: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // clearing pass runs to its end before any request is taken
   a_clear_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && !status.clear_last) |=> (state_ff == ST_CLEAR))
      else $error("clearing pass left early");

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.load, cmd.step, cmd.finish}))
      else $error("overlapping datapath commands");

   a_wall_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && status.wall)
         |=> (state_ff == ST_DONE && fin_status_ff == ddarw_pkg::STATUS_WALL))
      else $error("wall did not end the walk");

endmodule

`default_nettype wire

[sv/ddarw_dp.sv]
// ----------------------------------------------------------------------------
// ddarw_dp
// Walker datapath: wall map, walk registers, saturating distance adders and
// the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddarw_dp #(
   parameter int MAP_SIZE  = ddarw_pkg::MAP_SIZE_DEF,
   parameter int MAX_STEPS = ddarw_pkg::MAX_STEPS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ddarw_pkg::dp_cmd_type           cmd,
   output      ddarw_pkg::dp_status_type        status,
   input  wire logic                            req_cmd,
   input  wire logic [ddarw_pkg::PW-1:0]        req_pos_x,
   input  wire logic [ddarw_pkg::PW-1:0]        req_pos_y,
   input  wire logic [ddarw_pkg::VW-1:0]        req_cell_value,
   input  wire logic [ddarw_pkg::QW-1:0]        req_side_x,
   input  wire logic [ddarw_pkg::QW-1:0]        req_side_y,
   input  wire logic [ddarw_pkg::QW-1:0]        req_delta_x,
   input  wire logic [ddarw_pkg::QW-1:0]        req_delta_y,
   input  wire logic signed [ddarw_pkg::SW-1:0] req_step_x,
   input  wire logic signed [ddarw_pkg::SW-1:0] req_step_y,
   ddarw_rsp_if.source                          rsp_bus
);

   localparam int PW     = ddarw_pkg::PW;
   localparam int QW     = ddarw_pkg::QW;
   localparam int SW     = ddarw_pkg::SW;
   localparam int AW     = $clog2(MAP_SIZE);
   // one spare bit so a step off either edge lands at or above MAP_SIZE
   localparam int XW     = ((AW > PW) ? AW : PW) + 1;
   localparam int NW     = $clog2(MAX_STEPS + 1);
   localparam int RAW    = 2 * AW;
   localparam int RDEPTH = 1 << RAW;

   localparam logic [XW-1:0] GRID_LIM  = XW'(MAP_SIZE);
   localparam logic [NW-1:0] STEP_LIM  = NW'(MAX_STEPS);

   function automatic logic [XW-1:0] step_delta(input logic [SW-1:0] code);
      logic [XW-1:0] d;
      unique case (code)
         2'b00:   d = '0;
         2'b01:   d = XW'(1);
         default: d = '1;   // both negative codes move one cell down
      endcase
      return d;
   endfunction

   // walk state
   logic [RAW-1:0] clr_addr_ff;
   logic [XW-1:0]  cx_ff, cy_ff;
   logic [PW-1:0]  lx_ff, ly_ff;
   logic [QW-1:0]  sdx_ff, sdy_ff, ddx_ff, ddy_ff;
   logic [SW-1:0]  stx_ff, sty_ff;
   logic           side_ff;
   logic [NW-1:0]  n_ff;

   // response register
   logic                  rsp_valid_ff;
   ddarw_pkg::status_type rsp_status_ff;
   logic [PW-1:0]         rsp_hit_x_ff, rsp_hit_y_ff;
   logic                  rsp_side_ff;
   logic [QW-1:0]         rsp_sdx_ff, rsp_sdy_ff;

   logic [XW-1:0]  px_w, py_w, nx, ny;
   logic           sel_x;
   logic [QW:0]    sum_x, sum_y;
   logic [QW-1:0]  sat_x, sat_y;
   logic           wr_en, wr_data, rd_data;
   logic [RAW-1:0] wr_addr, rd_addr;

   always_comb begin
      px_w  = {{(XW-PW){1'b0}}, req_pos_x};
      py_w  = {{(XW-PW){1'b0}}, req_pos_y};
      sel_x = (sdx_ff < sdy_ff);   // tie goes to the y axis
      sum_x = {1'b0, sdx_ff} + {1'b0, ddx_ff};
      sum_y = {1'b0, sdy_ff} + {1'b0, ddy_ff};
      sat_x = sum_x[QW] ? '1 : sum_x[QW-1:0];
      sat_y = sum_y[QW] ? '1 : sum_y[QW-1:0];
      nx    = sel_x ? (cx_ff + step_delta(stx_ff)) : cx_ff;
      ny    = sel_x ? cy_ff : (cy_ff + step_delta(sty_ff));

      status.clear_last    = (clr_addr_ff == '1);
      status.req_cast      = (req_cmd == ddarw_pkg::CMD_CAST);
      status.start_in_grid = (px_w < GRID_LIM) && (py_w < GRID_LIM);
      status.next_in_grid  = (nx < GRID_LIM) && (ny < GRID_LIM);
      status.wall          = rd_data;
      status.step_limit    = (n_ff == STEP_LIM);
      status.out_free      = !rsp_valid_ff || rsp_bus.ready;

      rd_addr = {nx[AW-1:0], ny[AW-1:0]};
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = 1'b0;
      end else begin
         wr_en   = cmd.load && (req_cmd == ddarw_pkg::CMD_WRITE) && status.start_in_grid;
         wr_addr = {px_w[AW-1:0], py_w[AW-1:0]};
         wr_data = (req_cell_value == ddarw_pkg::WALL_CHAR);
      end
   end

   ddarw_ram #(
      .WIDTH (1),
      .DEPTH (RDEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + RAW'(1);
         end
         if (cmd.load) begin
            n_ff <= '0;
         end else if (cmd.step) begin
            n_ff <= n_ff + NW'(1);
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff   <= px_w;
         cy_ff   <= py_w;
         lx_ff   <= req_pos_x;
         ly_ff   <= req_pos_y;
         sdx_ff  <= req_side_x;
         sdy_ff  <= req_side_y;
         ddx_ff  <= req_delta_x;
         ddy_ff  <= req_delta_y;
         stx_ff  <= req_step_x;
         sty_ff  <= req_step_y;
         side_ff <= 1'b0;
      end else if (cmd.step) begin
         cx_ff <= nx;
         cy_ff <= ny;
         if (sel_x) begin
            sdx_ff  <= sat_x;
            side_ff <= 1'b0;
         end else begin
            sdy_ff  <= sat_y;
            side_ff <= 1'b1;
         end
         // keep the last cell inside the grid
         if (status.next_in_grid) begin
            lx_ff <= nx[PW-1:0];
            ly_ff <= ny[PW-1:0];
         end
      end

      if (cmd.finish) begin
         rsp_status_ff <= cmd.fin_status;
         rsp_hit_x_ff  <= lx_ff;
         rsp_hit_y_ff  <= ly_ff;
         if (cmd.fin_status == ddarw_pkg::STATUS_WRITE) begin
            rsp_side_ff <= 1'b0;
            rsp_sdx_ff  <= '0;
            rsp_sdy_ff  <= '0;
         end else begin
            rsp_side_ff <= side_ff;
            rsp_sdx_ff  <= sdx_ff;
            rsp_sdy_ff  <= sdy_ff;
         end
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.hit_x      = rsp_hit_x_ff;
   assign rsp_bus.hit_y      = rsp_hit_y_ff;
   assign rsp_bus.hit_side   = rsp_side_ff;
   assign rsp_bus.end_side_x = rsp_sdx_ff;
   assign rsp_bus.end_side_y = rsp_sdy_ff;

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (n_ff <= STEP_LIM))
      else $error("step count beyond limit");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_bus.valid)
      else $error("finished response not presented");

   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && cmd.fin_status == ddarw_pkg::STATUS_WRITE)
         |=> (!rsp_side_ff && rsp_sdx_ff == '0 && rsp_sdy_ff == '0))
      else $error("write response carries walk data");

endmodule

`default_nettype wire

[sv/dda_grid_ray_walk_core.sv]
// ----------------------------------------------------------------------------
// dda_grid_ray_walk_core
// Grid ray walker: wall map storage and DDA ray casting over the map.
// ----------------------------------------------------------------------------
// A write request stores one map cell when it lies in the grid (a wall when
// its byte is 49) and returns a write-done response. A cast request walks the
// grid from its start cell, one cell per step along the axis with the smaller
// side distance, and stops at the first wall, on leaving the grid, or after
// MAX_STEPS steps. Each step passes through the STEP and CHECK states because
// the wall bit comes from the map RAM's registered read port. One request is
// in flight at a time; a new request is taken while the previous response
// still waits in the response register. After reset the map RAM is cleared
// one entry a cycle over all 2^(2*clog2(MAP_SIZE)) entries (4096 at MAP_SIZE
// 64), and no request is accepted until that pass ends.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_grid_ray_walk_core #(
   parameter int MAP_SIZE  = ddarw_pkg::MAP_SIZE_DEF,
   parameter int MAX_STEPS = ddarw_pkg::MAX_STEPS_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   ddarw_req_if.sink   req_bus,
   ddarw_rsp_if.source rsp_bus
);

   ddarw_pkg::dp_cmd_type    dp_cmd;
   ddarw_pkg::dp_status_type dp_status;
   logic                     ctrl_ready;

   // sequencer: owns the request handshake and the step loop
   ddarw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ctrl_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   assign req_bus.ready = ctrl_ready;

   // datapath: map RAM, walk registers, response register
   ddarw_dp #(
      .MAP_SIZE  (MAP_SIZE),
      .MAX_STEPS (MAX_STEPS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .status         (dp_status),
      .req_cmd        (req_bus.cmd),
      .req_pos_x      (req_bus.pos_x),
      .req_pos_y      (req_bus.pos_y),
      .req_cell_value (req_bus.cell_value),
      .req_side_x     (req_bus.side_x),
      .req_side_y     (req_bus.side_y),
      .req_delta_x    (req_bus.delta_x),
      .req_delta_y    (req_bus.delta_y),
      .req_step_x     (req_bus.step_x),
      .req_step_y     (req_bus.step_y),
      .rsp_bus        (rsp_bus)
   );

endmodule

`default_nettype wire
